// ===== rtl/rcpa_pkg.sv =====
// Shared types, widths and codes of the page-frame allocator.
`default_nettype none

package rcpa_pkg;

  // Default sizing of the page pool and owner mask
  localparam int unsigned NUM_PAGES_DEF  = 65536;
  localparam int unsigned OWNER_BITS_DEF = 64;

  // Fixed field widths of the command and result words
  localparam int unsigned CMD_W    = 4;
  localparam int unsigned PAGE_W   = 16;
  localparam int unsigned REF_W    = 16;
  localparam int unsigned OID_W    = 6;
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FREE_W   = 17;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SEED     = 4'd0,
    CMD_ALLOC    = 4'd1,
    CMD_FREE     = 4'd2,
    CMD_INC_REF  = 4'd3,
    CMD_DEC_REF  = 4'd4,
    CMD_SET_REF  = 4'd5,
    CMD_SET_BIT  = 4'd6,
    CMD_CLR_BIT  = 4'd7,
    CMD_SET_MASK = 4'd8
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_RMW
  } state_e;

  // Control decisions of the table update
  typedef struct packed {
    logic    we;
    logic    push;
    logic    show;
    status_e status;
  } upd_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rcpa_ifs.sv =====
// Valid/ready channel interfaces for command, result and configuration words.
`default_nettype none

interface rcpa_req_if import rcpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [PAGE_W-1:0] page;
  logic [REF_W-1:0]  ref_value;
  logic [OID_W-1:0]  owner_id;
  logic [MASK_W-1:0] owner_mask_in;

  modport source (output valid, cmd, page, ref_value, owner_id, owner_mask_in,
                  input ready);
  modport sink (input valid, cmd, page, ref_value, owner_id, owner_mask_in,
                output ready);
endinterface

interface rcpa_rsp_if import rcpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   page_out;
  logic [REF_W-1:0]    ref_count;
  logic [MASK_W-1:0]   owner_mask;
  logic [FREE_W-1:0]   free_count;

  modport source (output valid, status, page_out, ref_count, owner_mask, free_count,
                  input ready);
  modport sink (input valid, status, page_out, ref_count, owner_mask, free_count,
                output ready);
endinterface

interface rcpa_cfg_if import rcpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rcpa_ram.sv =====
// Single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module rcpa_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rcpa_update.sv =====
// Per-command modify step of one page-table entry.
`default_nettype none

module rcpa_update import rcpa_pkg::*; #(
  parameter int unsigned OWNER_BITS = OWNER_BITS_DEF
) (
  input  wire logic [CMD_W-1:0]      cmd_i,
  input  wire logic                  in_pool_i,
  input  wire logic                  below_first_i,
  input  wire logic                  stack_empty_i,
  input  wire logic                  stack_full_i,
  input  wire logic [REF_W-1:0]      ref_value_i,
  input  wire logic [OID_W-1:0]      owner_id_i,
  input  wire logic [OWNER_BITS-1:0] mask_i,
  input  wire logic [REF_W-1:0]      rd_ref_i,
  input  wire logic [OWNER_BITS-1:0] rd_own_i,
  output logic      [REF_W-1:0]      new_ref_o,
  output logic      [OWNER_BITS-1:0] new_own_o,
  output upd_ctl_t                   ctl_o
);

  logic release_pg;
  logic oid_ok;

  assign oid_ok = 32'(owner_id_i) < OWNER_BITS;

  // Decide the new entry and the side effects of the command
  always_comb begin
    new_ref_o       = rd_ref_i;
    new_own_o       = rd_own_i;
    release_pg      = 1'b0;
    ctl_o.we        = 1'b0;
    ctl_o.show      = in_pool_i;
    ctl_o.status    = ST_OK;
    if (cmd_i == CMD_ALLOC) begin
      if (stack_empty_i) begin
        ctl_o.status = ST_EMPTY;
        ctl_o.show   = 1'b0;
      end else begin
        new_ref_o  = REF_W'(1);
        ctl_o.we   = 1'b1;
        ctl_o.show = 1'b1;
      end
    end else if (!in_pool_i) begin
      ctl_o.status = ST_RANGE;
    end else begin
      case (cmd_i)
        CMD_SEED, CMD_FREE: begin
          if (below_first_i) begin
            ctl_o.status = ST_RANGE;
          end else if (cmd_i == CMD_SEED || rd_ref_i <= REF_W'(1)) begin
            release_pg = 1'b1;
          end else begin
            new_ref_o = rd_ref_i - REF_W'(1);
            ctl_o.we  = 1'b1;
          end
        end
        CMD_INC_REF: begin
          if (rd_ref_i != '1) begin
            new_ref_o = rd_ref_i + REF_W'(1);
          end
          ctl_o.we = 1'b1;
        end
        CMD_DEC_REF: begin
          if (rd_ref_i != '0) begin
            new_ref_o = rd_ref_i - REF_W'(1);
          end
          ctl_o.we = 1'b1;
        end
        CMD_SET_REF: begin
          new_ref_o = ref_value_i;
          ctl_o.we  = 1'b1;
        end
        CMD_SET_BIT: begin
          if (oid_ok) begin
            new_own_o = rd_own_i | (OWNER_BITS'(1) << owner_id_i);
          end
          ctl_o.we = 1'b1;
        end
        CMD_CLR_BIT: begin
          if (oid_ok) begin
            new_own_o = rd_own_i & ~(OWNER_BITS'(1) << owner_id_i);
          end
          ctl_o.we = 1'b1;
        end
        CMD_SET_MASK: begin
          new_own_o = mask_i;
          ctl_o.we  = 1'b1;
        end
        default: begin
          ctl_o.we = 1'b0;
        end
      endcase
      // Release: clear count and mask, push unless the stack is full
      if (release_pg) begin
        new_ref_o = '0;
        new_own_o = '0;
        ctl_o.we  = 1'b1;
      end
    end
    ctl_o.push = release_pg && !stack_full_i;
  end

endmodule

`default_nettype wire

// ===== rtl/refcounted_page_frame_allocator.sv =====
// Top level of the reference-counted page-frame allocator.
// A command word is accepted in S_IDLE, which reads the page table; S_RMW
// then modifies and writes back the entry and loads the result register
// once any earlier result has drained. An alloc that finds a page passes
// through S_POP, as the free stack is read first to learn which page-table
// entry to read. After reset the page table goes through a clearing pass
// over all NUM_PAGES entries (65536 by default), during which no command is
// accepted; configuration writes are always taken. A new command is taken
// while the previous result still waits to be drained.
`default_nettype none

module refcounted_page_frame_allocator import rcpa_pkg::*; #(
  parameter int unsigned NUM_PAGES  = NUM_PAGES_DEF,
  parameter int unsigned OWNER_BITS = OWNER_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rcpa_cfg_if.sink    cfg_i,
  rcpa_req_if.sink    req_i,
  rcpa_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W   = $clog2(NUM_PAGES);
  localparam int unsigned DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int unsigned ENT_W   = REF_W + OWNER_BITS;

  state_e state_q, state_d;

  logic [PAGE_W-1:0]     first_q;
  logic [IDX_W-1:0]      clr_q;
  logic [DEPTH_W-1:0]    depth_q, depth_d;

  // Latched command word
  logic [CMD_W-1:0]      cmd_q;
  logic [PAGE_W-1:0]     page_q;
  logic [IDX_W-1:0]      idx_q;
  logic [REF_W-1:0]      rv_q;
  logic [OID_W-1:0]      oid_q;
  logic [OWNER_BITS-1:0] mask_q;
  logic                  in_pool_q;
  logic                  below_q;
  logic                  empty_q;

  // Result register
  logic                  rsp_valid_q;
  logic [STATUS_W-1:0]   rsp_status_q;
  logic [PAGE_W-1:0]     rsp_page_q;
  logic [REF_W-1:0]      rsp_ref_q;
  logic [MASK_W-1:0]     rsp_mask_q;
  logic [FREE_W-1:0]     rsp_free_q;

  logic                  accept;
  logic                  commit;
  logic                  clr_last;
  logic                  req_alloc;
  logic                  stack_empty;
  logic                  stack_full;

  logic                  tbl_we;
  logic [IDX_W-1:0]      tbl_waddr;
  logic [ENT_W-1:0]      tbl_wdata;
  logic                  tbl_re;
  logic [IDX_W-1:0]      tbl_raddr;
  logic [ENT_W-1:0]      tbl_rdata;

  logic                  stk_we;
  logic                  stk_re;
  logic [PAGE_W-1:0]     stk_rdata;
  logic [IDX_W-1:0]      pop_idx;

  logic [REF_W-1:0]      new_ref;
  logic [OWNER_BITS-1:0] new_own;
  upd_ctl_t              ctl;

  assign stack_empty = depth_q == '0;
  assign stack_full  = depth_q == DEPTH_W'(NUM_PAGES);
  assign clr_last    = clr_q == IDX_W'(NUM_PAGES - 1);
  assign req_alloc   = req_i.cmd == CMD_ALLOC;
  assign pop_idx     = IDX_W'(stk_rdata);

  // Handshakes
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = state_q == S_IDLE;
  assign accept      = req_i.valid && req_i.ready;
  assign commit      = (state_q == S_RMW) && (!rsp_valid_q || rsp_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = (req_alloc && !stack_empty) ? S_POP : S_RMW;
        end
      end
      S_POP: begin
        state_d = S_RMW;
      end
      S_RMW: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Memory port controls
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = idx_q;
    tbl_wdata = {new_ref, new_own};
    tbl_re    = 1'b0;
    tbl_raddr = IDX_W'(req_i.page);
    stk_re    = 1'b0;
    stk_we    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_q;
        tbl_wdata = '0;
      end
      S_IDLE: begin
        tbl_re = accept && !req_alloc;
        stk_re = accept && req_alloc && !stack_empty;
      end
      S_POP: begin
        tbl_re    = 1'b1;
        tbl_raddr = pop_idx;
      end
      S_RMW: begin
        tbl_we = commit && ctl.we;
        stk_we = commit && ctl.push;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // Stack depth after the command
  always_comb begin
    depth_d = depth_q;
    if (commit) begin
      if (cmd_q == CMD_ALLOC && !empty_q) begin
        depth_d = depth_q - DEPTH_W'(1);
      end else if (ctl.push) begin
        depth_d = depth_q + DEPTH_W'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      depth_q     <= '0;
      first_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      if (cfg_i.valid && cfg_i.ready) begin
        first_q <= cfg_i.data;
      end
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Hold the command word; swap in the popped page for alloc
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= req_i.cmd;
      page_q    <= req_i.page;
      idx_q     <= IDX_W'(req_i.page);
      rv_q      <= req_i.ref_value;
      oid_q     <= req_i.owner_id;
      mask_q    <= req_i.owner_mask_in[OWNER_BITS-1:0];
      in_pool_q <= 32'(req_i.page) < NUM_PAGES;
      below_q   <= req_i.page < first_q;
      empty_q   <= req_alloc && stack_empty;
    end else if (state_q == S_POP) begin
      idx_q  <= pop_idx;
      page_q <= PAGE_W'(pop_idx);
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_status_q <= ctl.status;
      rsp_page_q   <= empty_q ? '0 : page_q;
      rsp_ref_q    <= ctl.show ? new_ref : '0;
      rsp_mask_q   <= ctl.show ? MASK_W'(new_own) : '0;
      rsp_free_q   <= FREE_W'(depth_d);
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.page_out   = rsp_page_q;
  assign rsp_o.ref_count  = rsp_ref_q;
  assign rsp_o.owner_mask = rsp_mask_q;
  assign rsp_o.free_count = rsp_free_q;

  // Page table: count and owner mask per page
  rcpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Free stack of page indices
  rcpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (PAGE_W),
    .AW    (IDX_W)
  ) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (IDX_W'(depth_q)),
    .wdata_i (page_q),
    .re_i    (stk_re),
    .raddr_i (IDX_W'(depth_q - DEPTH_W'(1))),
    .rdata_o (stk_rdata)
  );

  // Entry modify step
  rcpa_update #(
    .OWNER_BITS (OWNER_BITS)
  ) u_upd (
    .cmd_i         (cmd_q),
    .in_pool_i     (in_pool_q),
    .below_first_i (below_q),
    .stack_empty_i (empty_q),
    .stack_full_i  (stack_full),
    .ref_value_i   (rv_q),
    .owner_id_i    (oid_q),
    .mask_i        (mask_q),
    .rd_ref_i      (tbl_rdata[ENT_W-1:OWNER_BITS]),
    .rd_own_i      (tbl_rdata[OWNER_BITS-1:0]),
    .new_ref_o     (new_ref),
    .new_own_o     (new_own),
    .ctl_o         (ctl)
  );

endmodule

`default_nettype wire
